>>> rtl/pidc_pkg.sv
// Package for the PI duty controller: field widths, register indexes,
// reset values, duty limits and the clamp flag type.
// No dependencies; every rtl file imports it.
package pidc_pkg;

    // Field and register widths
    localparam int TEMP_W      = 16;
    localparam int ERR_W       = 17;
    localparam int GAIN_W      = 24;
    localparam int DUTY_W      = 10;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 24;
    localparam int S_DATA_W    = 16;
    localparam int M_DATA_W    = 32;

    // Default accumulator width
    localparam int ACC_WIDTH_DEF = 32;

    // Gains are Q8.16 and temperatures carry 8 fraction bits
    localparam int FRAC_BITS = 24;
    localparam int DUTY_TOP  = 999;
    localparam int DUTY_MAX  = 1000;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_TEMP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN  = 2'd2;

    // Register reset values
    localparam logic signed [TEMP_W-1:0] TARGET_TEMP_RST = 16'sd6400;
    localparam logic [GAIN_W-1:0]        PROP_GAIN_RST   = 24'd4648468;
    localparam logic [GAIN_W-1:0]        INTEG_GAIN_RST  = 24'd982;

    // Clamp flag reported with each duty value
    typedef enum logic [1:0] {
        CLAMP_NONE = 2'd0,
        CLAMP_HIGH = 2'd1,
        CLAMP_LOW  = 2'd2
    } clamp_t;

endpackage

>>> rtl/pidc_clamp.sv
// Sum of the three partial products and the duty clamp to 0..1000.
// Depends on pidc_pkg.
module pidc_clamp #(
    parameter int ACC_WIDTH = pidc_pkg::ACC_WIDTH_DEF
) (
    input  logic signed [pidc_pkg::GAIN_W+ACC_WIDTH/2:0]      prod_hi,
    input  logic [pidc_pkg::GAIN_W+(ACC_WIDTH+1)/2-1:0]        prod_lo,
    input  logic signed [pidc_pkg::GAIN_W+pidc_pkg::ERR_W:0]  prod_err,
    output logic [pidc_pkg::DUTY_W-1:0]                       duty,
    output pidc_pkg::clamp_t                                  clamp
);
    import pidc_pkg::*;

    localparam int LO_W = (ACC_WIDTH + 1) / 2;
    localparam int SW   = ACC_WIDTH + GAIN_W + 2;
    localparam logic signed [SW-1:0] TOP_S = SW'(DUTY_TOP) << FRAC_BITS;

    logic signed [SW-1:0] sum_s;

    // Rebuild the full-precision sum in units of 2^-24 duty counts
    assign sum_s = (SW'(prod_hi) <<< LO_W)
                 + SW'($signed({1'b0, prod_lo}))
                 + SW'(prod_err);

    // Clamp above 999.0 and below zero, truncate otherwise
    always_comb
    begin
        if (sum_s > TOP_S)
        begin
            duty  = DUTY_W'(DUTY_MAX);
            clamp = CLAMP_HIGH;
        end
        else if (sum_s[SW-1])
        begin
            duty  = '0;
            clamp = CLAMP_LOW;
        end
        else
        begin
            duty  = sum_s[FRAC_BITS+DUTY_W-1:FRAC_BITS];
            clamp = CLAMP_NONE;
        end
    end

endmodule

>>> rtl/pi_duty_controller_top.sv
// PI duty controller with trapezoidal integral: top level.
// Pipeline: error and accumulator stage, product stage, result register.
// Throughput: one request per cycle while s_tready is high; the accumulator
// add and saturate is combinational around its register.
// Stages advance independently on stalls.
// Reset: rst_n clears the accumulator, last error and valid bits, and loads
// the register defaults. Depends on pidc_pkg and pidc_clamp.
module pi_duty_controller_top #(
    parameter int ACC_WIDTH = pidc_pkg::ACC_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Configuration write port
    input  logic                                 cfg_wr_en,
    input  logic [pidc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pidc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    // Sample stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [pidc_pkg::S_DATA_W-1:0]        s_tdata,   // [15:0] sample_temp
    // Result stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [pidc_pkg::M_DATA_W-1:0]        m_tdata    // [9:0] duty,
                                                            // [26:10] error_out,
                                                            // [28:27] clamped
);
    import pidc_pkg::*;

    localparam int LO_W = (ACC_WIDTH + 1) / 2;
    localparam int HI_W = ACC_WIDTH - LO_W;
    localparam int AW2  = ACC_WIDTH + 2;
    localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};
    localparam int PAD_W = M_DATA_W - DUTY_W - ERR_W - 2;

    // Configuration registers
    logic signed [TEMP_W-1:0]    target_temp_reg;
    logic [GAIN_W-1:0]           prop_gain_reg;
    logic [GAIN_W-1:0]           integ_gain_reg;

    // Loop state, also the first pipeline stage
    logic signed [ACC_WIDTH-1:0] integral_sum_reg;
    logic signed [ACC_WIDTH-1:0] integral_sum_next;
    logic signed [ERR_W-1:0]     last_error_reg;
    logic signed [ERR_W-1:0]     last_error_next;
    logic                        a_valid_reg;

    // Product stage
    logic signed [GAIN_W+HI_W:0]   prod_hi_reg;
    logic signed [GAIN_W+HI_W:0]   prod_hi_next;
    logic [GAIN_W+LO_W-1:0]        prod_lo_reg;
    logic [GAIN_W+LO_W-1:0]        prod_lo_next;
    logic signed [GAIN_W+ERR_W:0]  prod_err_reg;
    logic signed [GAIN_W+ERR_W:0]  prod_err_next;
    logic signed [ERR_W-1:0]       p_err_reg;
    logic                          p_valid_reg;

    // Result register
    logic [DUTY_W-1:0]             duty_reg;
    logic [DUTY_W-1:0]             duty_next;
    logic signed [ERR_W-1:0]       err_out_reg;
    clamp_t                        clamp_reg;
    clamp_t                        clamp_next;
    logic                          out_valid_reg;

    logic                          out_ready;
    logic                          p_ready;
    logic                          accept;
    logic signed [AW2-1:0]         acc_sum;
    logic signed [GAIN_W:0]        integ_gain_s;
    logic signed [GAIN_W:0]        prop_gain_s;
    logic signed [HI_W-1:0]        acc_hi;
    logic [LO_W-1:0]               acc_lo;

    // Per-stage flow control: a stage loads when empty or draining
    assign out_ready = !out_valid_reg || m_tready;
    assign p_ready   = !p_valid_reg || out_ready;
    assign s_tready  = !a_valid_reg || p_ready;
    assign accept    = s_tvalid && s_tready;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_temp_reg <= TARGET_TEMP_RST;
            prop_gain_reg   <= PROP_GAIN_RST;
            integ_gain_reg  <= INTEG_GAIN_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_TARGET_TEMP: target_temp_reg <= cfg_wdata[TEMP_W-1:0];
                REG_PROP_GAIN:   prop_gain_reg   <= cfg_wdata[GAIN_W-1:0];
                REG_INTEG_GAIN:  integ_gain_reg  <= cfg_wdata[GAIN_W-1:0];
                default:         ;
            endcase
        end
    end

    // Error and saturating trapezoidal accumulator
    always_comb
    begin
        last_error_next = ERR_W'(target_temp_reg) - ERR_W'($signed(s_tdata[TEMP_W-1:0]));
        acc_sum = AW2'(integral_sum_reg) + AW2'(last_error_next) + AW2'(last_error_reg);
        if (acc_sum[AW2-1:ACC_WIDTH-1] == '0 || acc_sum[AW2-1:ACC_WIDTH-1] == '1)
            integral_sum_next = acc_sum[ACC_WIDTH-1:0];
        else if (acc_sum[AW2-1])
            integral_sum_next = ACC_MIN;
        else
            integral_sum_next = ACC_MAX;
    end

    // Hold the loop state; it advances only on an accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integral_sum_reg <= '0;
            last_error_reg   <= '0;
        end
        else if (accept)
        begin
            integral_sum_reg <= integral_sum_next;
            last_error_reg   <= last_error_next;
        end
    end

    // Split the accumulator so no product is wider than 25 x 17 bits at the default width
    always_comb
    begin
        integ_gain_s  = $signed({1'b0, integ_gain_reg});
        prop_gain_s   = $signed({1'b0, prop_gain_reg});
        acc_hi        = integral_sum_reg[ACC_WIDTH-1:LO_W];
        acc_lo        = integral_sum_reg[LO_W-1:0];
        prod_hi_next  = integ_gain_s * acc_hi;
        prod_lo_next  = integ_gain_reg * acc_lo;
        prod_err_next = prop_gain_s * last_error_reg;
    end

    always_ff @(posedge clk)
    begin
        if (a_valid_reg && p_ready)
        begin
            prod_hi_reg  <= prod_hi_next;
            prod_lo_reg  <= prod_lo_next;
            prod_err_reg <= prod_err_next;
            p_err_reg    <= last_error_reg;
        end
    end

    pidc_clamp #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_clamp (
        .prod_hi  (prod_hi_reg),
        .prod_lo  (prod_lo_reg),
        .prod_err (prod_err_reg),
        .duty     (duty_next),
        .clamp    (clamp_next)
    );

    // Result register
    always_ff @(posedge clk)
    begin
        if (p_valid_reg && out_ready)
        begin
            duty_reg    <= duty_next;
            err_out_reg <= p_err_reg;
            clamp_reg   <= clamp_next;
        end
    end

    // Valid bits of the three stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            p_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                a_valid_reg <= s_tvalid;
            if (p_ready)
                p_valid_reg <= a_valid_reg;
            if (out_ready)
                out_valid_reg <= p_valid_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, clamp_reg, err_out_reg, duty_reg};

endmodule

>>> tb/pi_duty_controller_top_test.sv
// Self-checking testbench for the PI duty controller top level.
// Drives temperature samples, predicts duty, error and clamp flag from its
// own copy of the settings and state; depends on pidc_pkg and the rtl.
`timescale 1ns / 1ps

module pi_duty_controller_top_test;
    import pidc_pkg::*;

    // Index the block does not decode; writes to it must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam longint ACC_HI  = (longint'(1) <<< (ACC_WIDTH_DEF - 1)) - 1;
    localparam longint ACC_LO  = -ACC_HI - 1;
    localparam longint S_TOP   = longint'(DUTY_TOP) <<< FRAC_BITS;
    localparam int     RUN_LEN = 300;

    typedef struct packed {
        logic [DUTY_W-1:0]       duty;
        logic signed [ERR_W-1:0] error;
        clamp_t                  flag;
    } duty_result_t;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;

    // Predictor copy of the settings and the controller state
    logic signed [TEMP_W-1:0] set_temp = TARGET_TEMP_RST;
    logic [GAIN_W-1:0]        kp_gain  = PROP_GAIN_RST;
    logic [GAIN_W-1:0]        ki_gain  = INTEG_GAIN_RST;
    longint                   integ_acc = 0;
    longint                   last_err  = 0;

    logic [TEMP_W-1:0] pending_samples[$];
    duty_result_t      expected_results[$];
    int                send_idle_pct = 18;
    int                recv_idle_pct = 52;
    int                fail_count    = 0;

    pi_duty_controller_top #(
        .ACC_WIDTH(ACC_WIDTH_DEF)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

    // Advance the controller by one sample and return the duty it should give
    function automatic duty_result_t predict_duty(input logic [TEMP_W-1:0] sample);
        longint       err;
        longint       acc;
        longint       sum;
        duty_result_t res;
        err = longint'(set_temp) - longint'($signed(sample));
        acc = integ_acc + err + last_err;
        if (acc > ACC_HI)
            acc = ACC_HI;
        if (acc < ACC_LO)
            acc = ACC_LO;
        integ_acc = acc;
        last_err  = err;
        // Full-precision sum in units of 2^-24 duty counts
        sum = longint'(kp_gain) * err + longint'(ki_gain) * acc;
        res.error = err[ERR_W-1:0];
        if (sum > S_TOP)
        begin
            res.duty = DUTY_W'(DUTY_MAX);
            res.flag = CLAMP_HIGH;
        end
        else if (sum < 0)
        begin
            res.duty = '0;
            res.flag = CLAMP_LOW;
        end
        else
        begin
            res.duty = DUTY_W'(sum >>> FRAC_BITS);
            res.flag = CLAMP_NONE;
        end
        return res;
    endfunction

    // Mostly samples whose error keeps the duty in range, some anywhere
    function automatic logic [TEMP_W-1:0] pick_sample();
        longint span;
        longint offset;
        longint value;
        if ($urandom_range(0, 99) < 20)
            return TEMP_W'($urandom);
        if (kp_gain == 0)
            span = 65535;
        else
            span = (longint'(DUTY_MAX) <<< FRAC_BITS) / longint'(kp_gain);
        if (span > 65535)
            span = 65535;
        if (span < 4)
            span = 4;
        offset = longint'($urandom_range(0, 32'(span + span / 4))) - span / 4;
        value  = longint'(set_temp) - offset;
        if (value > 32767)
            value = 32767;
        if (value < -32768)
            value = -32768;
        return value[TEMP_W-1:0];
    endfunction

    task automatic check_duty_result(input logic [M_DATA_W-1:0] word);
        duty_result_t want;
        duty_result_t got;
        got.duty  = word[9:0];
        got.error = word[26:10];
        got.flag  = clamp_t'(word[28:27]);
        if (expected_results.size() == 0)
        begin
            $display("%0t: result 0x%08h with no request outstanding", $time, word);
            fail_count++;
            return;
        end
        want = expected_results.pop_front();
        if (got.duty !== want.duty)
        begin
            $display("%0t: duty expected %0d actual %0d", $time, want.duty, got.duty);
            fail_count++;
        end
        if (got.error !== want.error)
        begin
            $display("%0t: error_out expected %0d actual %0d",
                     $time, want.error, got.error);
            fail_count++;
        end
        if (got.flag !== want.flag)
        begin
            $display("%0t: clamped expected %0d actual %0d",
                     $time, want.flag, got.flag);
            fail_count++;
        end
    endtask

    // Drive sample requests; predict each one at the edge that accepts it
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_results.push_back(predict_duty(s_tdata));
            if (!s_tvalid || s_tready)
            begin
                if (pending_samples.size() != 0 &&
                    $urandom_range(0, 99) >= send_idle_pct)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_samples.pop_front();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Stall the result side at random and check every accepted result
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            if (m_tvalid && m_tready)
                check_duty_result(m_tdata);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_TARGET_TEMP: set_temp = value[TEMP_W-1:0];
            REG_PROP_GAIN:   kp_gain  = value;
            REG_INTEG_GAIN:  ki_gain  = value;
            default:         ;
        endcase
    endtask

    // Upper bits of the set point write carry noise the block must drop
    task automatic load_settings(input logic [TEMP_W-1:0] target,
                                 input logic [GAIN_W-1:0] kp,
                                 input logic [GAIN_W-1:0] ki);
        write_reg(REG_TARGET_TEMP, {8'($urandom), target});
        write_reg(REG_PROP_GAIN, kp);
        write_reg(REG_INTEG_GAIN, ki);
    endtask

    // Hold until every request is taken and every result has come back
    task automatic wait_idle();
        while (pending_samples.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_random(input int count);
        repeat (count) pending_samples.push_back(pick_sample());
        wait_idle();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: sample extremes, set point edge, alternating bits
        pending_samples.push_back(16'h8000);
        pending_samples.push_back(16'h7FFF);
        pending_samples.push_back(16'h0000);
        pending_samples.push_back(16'd6400);
        pending_samples.push_back(16'd6401);
        pending_samples.push_back(16'h5555);
        pending_samples.push_back(16'hAAAA);
        wait_idle();

        // Gain of 16 counts per degree, no integral: land on exactly 999.0
        load_settings(16'sd0, 24'h100000, 24'h000000);
        pending_samples.push_back(16'(-15984));
        pending_samples.push_back(16'(-15985));
        pending_samples.push_back(16'(-15983));
        pending_samples.push_back(16'd1);
        pending_samples.push_back(16'd0);
        wait_idle();

        // Largest gains with the most negative and most positive error
        load_settings(16'h8000, 24'hFFFFFF, 24'hFFFFFF);
        pending_samples.push_back(16'h7FFF);
        pending_samples.push_back(16'h8000);
        wait_idle();
        load_settings(16'h7FFF, 24'hFFFFFF, 24'h000000);
        pending_samples.push_back(16'h8000);
        pending_samples.push_back(16'h7FFF);
        wait_idle();

        // Default gains, then integral action alone
        load_settings(16'($urandom_range(4000, 9000)), PROP_GAIN_RST, INTEG_GAIN_RST);
        run_random(RUN_LEN);
        load_settings(16'($urandom_range(0, 12000)), 24'h0, 24'($urandom_range(1, 65535)));
        run_random(RUN_LEN);

        // Swap the stall pattern; a write to the undecoded index changes nothing
        send_idle_pct = 52;
        recv_idle_pct = 18;
        write_reg(REG_UNUSED, 24'($urandom));
        load_settings(16'($urandom), 24'($urandom_range(1 << 14, 1 << 23)),
                      24'($urandom_range(0, 4096)));
        run_random(RUN_LEN);
        load_settings(16'($urandom), 24'hFFFFFF, 24'hFFFFFF);
        run_random(RUN_LEN);

        // Full rate from here on
        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_settings(16'($urandom), 24'($urandom), 24'($urandom_range(0, 255)));
        run_random(RUN_LEN);

        load_settings(TARGET_TEMP_RST, PROP_GAIN_RST, INTEG_GAIN_RST);
        run_random(RUN_LEN);

        repeat (10) @(posedge clk);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
